// ===== rtl/bsfe_pkg.sv =====
// Shared constants and types of the byte-stuffing frame encoder.
package bsfe_pkg;

  localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
  localparam logic [7:0]  ESC_BYTE    = 8'h7D;
  localparam logic [7:0]  ESC_OFFSET  = 8'h7C;
  localparam logic [15:0] LIMIT_RESET = 16'd1024;

  // Most words one input word can cause: flag, two escaped pairs, flag.
  localparam int unsigned MAX_RES = 6;
  localparam int unsigned RES_W   = $clog2(MAX_RES + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_RES);

  // Register index decoded from paddr[2].
  localparam logic REG_FRAME_LIMIT = 1'b0;

  // One output word.
  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       overflow;
  } res_t;

  // Encoder state carried between input words.
  typedef struct packed {
    logic        in_frame;
    logic [7:0]  check_accum;
    logic [15:0] out_count;
    logic        discarding;
  } enc_state_t;

  // True for bytes that must be escaped.
  function automatic logic needs_esc(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

endpackage

// ===== rtl/bsfe_encode.sv =====
// Combinational encoder: one input word to its list of output words and next state.
module bsfe_encode (
  input  bsfe_pkg::enc_state_t st_i,
  input  logic [7:0]           data_i,
  input  logic                 last_i,
  input  logic [15:0]          limit_i,
  output bsfe_pkg::res_t       res_o [bsfe_pkg::MAX_RES],
  output logic [bsfe_pkg::RES_W-1:0] n_o,
  output bsfe_pkg::enc_state_t st_o
);
  import bsfe_pkg::*;

  always_comb begin
    logic [IDX_W-1:0] n;
    logic [15:0]      oc;
    logic [7:0]       ck;
    logic             ab;
    logic             done;
    n    = '0;
    oc   = st_i.out_count;
    ck   = st_i.check_accum;
    ab   = 1'b0;
    done = 1'b0;
    for (int i = 0; i < MAX_RES; i++) begin
      res_o[i] = '0;
    end
    st_o = st_i;
    n_o  = '0;

    if (st_i.discarding) begin
      // dropping words up to the end of the aborted frame
      if (last_i) begin
        st_o.discarding = 1'b0;
        st_o.in_frame   = 1'b0;
        st_o.out_count  = '0;
      end
    end else begin
      // open a frame
      if (!st_i.in_frame) begin
        res_o[n] = '{data: FLAG_BYTE, frame_end: 1'b0, overflow: 1'b0};
        n  = n + IDX_W'(1);
        oc = 16'd1;
        ck = '0;
      end
      ck = ck ^ data_i;

      // payload byte
      if (({1'b0, oc} + 17'd1) >= {1'b0, limit_i}) begin
        ab = 1'b1;
      end else begin
        if (needs_esc(data_i)) begin
          res_o[n]              = '{data: ESC_BYTE, frame_end: 1'b0, overflow: 1'b0};
          res_o[n + IDX_W'(1)]  = '{data: data_i - ESC_OFFSET, frame_end: 1'b0,
                                    overflow: 1'b0};
          n  = n + IDX_W'(2);
          oc = oc + 16'd2;
        end else begin
          res_o[n] = '{data: data_i, frame_end: 1'b0, overflow: 1'b0};
          n  = n + IDX_W'(1);
          oc = oc + 16'd1;
        end
        // checksum and closing flag
        if (last_i) begin
          if (({1'b0, oc} + 17'd1) >= {1'b0, limit_i}) begin
            ab = 1'b1;
          end else begin
            if (needs_esc(ck)) begin
              res_o[n]             = '{data: ESC_BYTE, frame_end: 1'b0, overflow: 1'b0};
              res_o[n + IDX_W'(1)] = '{data: ck - ESC_OFFSET, frame_end: 1'b0,
                                       overflow: 1'b0};
              n  = n + IDX_W'(2);
              oc = oc + 16'd2;
            end else begin
              res_o[n] = '{data: ck, frame_end: 1'b0, overflow: 1'b0};
              n  = n + IDX_W'(1);
              oc = oc + 16'd1;
            end
            if (oc >= limit_i) begin
              ab = 1'b1;
            end else begin
              res_o[n] = '{data: FLAG_BYTE, frame_end: 1'b1, overflow: 1'b0};
              n    = n + IDX_W'(1);
              done = 1'b1;
            end
          end
        end
      end

      // abort word
      if (ab) begin
        res_o[n] = '{data: 8'h00, frame_end: 1'b0, overflow: 1'b1};
        n_o = RES_W'(n) + RES_W'(1);
      end else begin
        n_o = RES_W'(n);
      end

      st_o.check_accum = ck;
      st_o.in_frame    = 1'b1;
      st_o.out_count   = oc;
      if ((ab && last_i) || done) begin
        st_o.in_frame  = 1'b0;
        st_o.out_count = '0;
      end else if (ab) begin
        st_o.discarding = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/byte_stuffing_frame_encoder.sv =====
// Top level: byte-stuffing frame encoder with XOR checksum and APB limit register.
// The first output word of an input word is registered and valid in the cycle after acceptance.
// Throughput: one output word per cycle while m_axis_tready is high; an input word yields
//   N output words (0..6), handed out one at a time by the single byte-wide output port.
// A new input word is taken in the cycle its predecessor's last word is handed off.
// Reset (rst_ni low, async): no frame open, checksum and count zero, frame_limit 1024.
module byte_stuffing_frame_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // is_last
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // run_last
  output logic [1:0]  m_axis_tuser,   // [0] frame_end, [1] overflow
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bsfe_pkg::*;

  logic [15:0]      limit_q;
  enc_state_t       st_q, st_d;
  res_t             buf_q [MAX_RES];
  res_t             res_d [MAX_RES];
  logic [RES_W-1:0] n_q, n_d;
  logic [IDX_W-1:0] idx_q;
  logic             in_acc, out_acc, last_out;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRAME_LIMIT) ? {16'h0000, limit_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FRAME_LIMIT)) begin
      limit_q <= pwdata[15:0];
    end
  end

  // encoder
  bsfe_encode u_enc (
    .st_i    (st_q),
    .data_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .limit_i (limit_q),
    .res_o   (res_d),
    .n_o     (n_d),
    .st_o    (st_d)
  );

  // handshakes
  assign m_axis_tvalid = (n_q != '0);
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign last_out      = out_acc && (RES_W'(idx_q) == (n_q - RES_W'(1)));
  assign s_axis_tready = (n_q == '0) || last_out;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // output word select
  assign m_axis_tdata = buf_q[idx_q].data;
  assign m_axis_tlast = (RES_W'(idx_q) == (n_q - RES_W'(1)));
  assign m_axis_tuser = {buf_q[idx_q].overflow, buf_q[idx_q].frame_end};

  // state, count and index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      n_q   <= '0;
      idx_q <= '0;
    end else if (in_acc) begin
      st_q  <= st_d;
      n_q   <= n_d;
      idx_q <= '0;
    end else if (last_out) begin
      n_q   <= '0;
      idx_q <= '0;
    end else if (out_acc) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  // result buffer, payload only
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MAX_RES; i++) begin
        buf_q[i] <= res_d[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (RES_W'(idx_q) < n_q))
    else $error("output index beyond buffered word count");

  a_ovf_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
    else $error("overflow word is not the last of its run");

  a_fe_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && !m_axis_tuser[1]))
    else $error("closing flag not last or marked overflow");

  a_discard_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && st_q.discarding) |=> !m_axis_tvalid)
    else $error("discarded word produced output");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output stalled");
`endif

endmodule
